[hdl/swvg_pkg.sv]
// Package for the schedule window valve gate: payload structs, window type,
// register indexes and day/margin constants. No dependencies.
package swvg_pkg;

    localparam int MINUTE_W   = 11;
    localparam int MARGIN_W   = 6;
    localparam int SLOT_W     = 23;
    localparam int SLOT_COUNT = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = SLOT_W;

    localparam logic [MINUTE_W-1:0] MIN_PER_DAY = MINUTE_W'(1440);
    localparam logic [MARGIN_W-1:0] MARGIN_MAX  = MARGIN_W'(60);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GATE_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEAD_MINUTES = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAG_MINUTES  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_WORD_0  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_WORD_1  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_WORD_2  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_WORD_3  = 3'd6;

    typedef struct packed {
        logic [MINUTE_W-1:0] minute_of_day;
        logic                clock_ok;
    } t_tick_in;

    typedef struct packed {
        logic                valve_open;
        logic                valve_changed;
        logic                window_hit;
        logic [MINUTE_W-1:0] window_start;
        logic [MINUTE_W-1:0] window_end;
    } t_tick_out;

    // Match result of one slot
    typedef struct packed {
        logic                hit;
        logic [MINUTE_W-1:0] start;
        logic [MINUTE_W-1:0] stop;
    } t_window;

endpackage

[hdl/schedule_window_valve_gate_core.sv]
// Top level of the schedule window valve gate: configuration registers,
// input register, valve state and result register. Depends on swvg_pkg
// and swvg_slot_match.
//
// Each transfer on the input channel is one minute tick; each tick yields
// exactly one result transfer. A tick is captured in an input register, then
// the four slot windows are widened and matched combinationally in parallel and
// the result lands in the output register, so a new tick can be taken every
// cycle when the output side is ready. The valve state bit updates as a
// result is loaded. Configuration writes take effect at once and are meant
// to happen only while no tick is in flight. Margin writes above 60 store 60;
// writes to indexes past the slot words are dropped.
module schedule_window_valve_gate_core
    import swvg_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Tick input channel
    input  logic                  i_tick_valid,
    output logic                  o_tick_ready,
    input  t_tick_in              i_tick,
    // Result channel
    output logic                  o_result_valid,
    input  logic                  i_result_ready,
    output t_tick_out             o_result
);

    // Configuration registers
    logic                r_gate_enable;
    logic [MARGIN_W-1:0] r_lead;
    logic [MARGIN_W-1:0] r_lag;
    logic [SLOT_W-1:0]   r_slot [SLOT_COUNT];

    // Pipeline registers and state
    logic      r_in_valid;
    t_tick_in  r_in;
    logic      r_out_valid;
    t_tick_out r_out;
    logic      r_valve;

    logic      out_free;
    logic      advance;
    t_window   slot_win [SLOT_COUNT];
    t_window   pick;
    t_tick_out n_out;
    logic      n_valve;
    logic [MARGIN_W-1:0] sat_margin;

    // Saturate margin writes to the allowed range
    assign sat_margin = (i_cfg_data > CFG_DATA_W'(MARGIN_MAX)) ? MARGIN_MAX
                                                               : i_cfg_data[MARGIN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gate_enable <= 1'b0;
            r_lead        <= '0;
            r_lag         <= '0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot[i] <= '0;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_GATE_ENABLE:  r_gate_enable <= i_cfg_data[0];
                REG_LEAD_MINUTES: r_lead        <= sat_margin;
                REG_LAG_MINUTES:  r_lag         <= sat_margin;
                REG_SLOT_WORD_0:  r_slot[0]     <= i_cfg_data;
                REG_SLOT_WORD_1:  r_slot[1]     <= i_cfg_data;
                REG_SLOT_WORD_2:  r_slot[2]     <= i_cfg_data;
                REG_SLOT_WORD_3:  r_slot[3]     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake: the input register moves on whenever the result slot frees up
    assign out_free     = !r_out_valid || i_result_ready;
    assign advance      = r_in_valid && out_free;
    assign o_tick_ready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_tick_ready) begin
            r_in_valid <= i_tick_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_tick_ready && i_tick_valid) begin
            r_in <= i_tick;
        end
    end

    // Match all slots in parallel
    for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_slot
        swvg_slot_match u_match (
            .i_slot_word (r_slot[g]),
            .i_lead      (r_lead),
            .i_lag       (r_lag),
            .i_minute    (r_in.minute_of_day),
            .o_window    (slot_win[g])
        );
    end

    // Take the lowest-index matching slot
    always_comb begin
        pick = '0;
        priority if (slot_win[0].hit) begin
            pick = slot_win[0];
        end else if (slot_win[1].hit) begin
            pick = slot_win[1];
        end else if (slot_win[2].hit) begin
            pick = slot_win[2];
        end else if (slot_win[3].hit) begin
            pick = slot_win[3];
        end else begin
            pick = '0;
        end
    end

    // Next valve state and result
    always_comb begin
        n_valve = r_valve;
        n_out   = '0;
        priority if (!r_gate_enable) begin
            n_valve = 1'b0;
        end else if (r_in.clock_ok && (r_in.minute_of_day < MIN_PER_DAY)) begin
            n_valve            = pick.hit;
            n_out.window_hit   = pick.hit;
            n_out.window_start = pick.start;
            n_out.window_end   = pick.stop;
        end else begin
            // Hold the valve on an invalid tick
            n_valve = r_valve;
        end
        n_out.valve_open    = n_valve;
        n_out.valve_changed = n_valve != r_valve;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valve     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_valve <= n_valve;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

`ifndef SYNTH
    // Held result always reflects the current valve state
    a_valve_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.valve_open == r_valve))
        else $error("result valve_open differs from valve state");

    // A window hit always opens the valve
    a_hit_opens: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.window_hit) |-> r_out.valve_open)
        else $error("window hit without open valve");

    // Window bounds are zero without a hit
    a_no_hit_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.window_hit) |->
            (r_out.window_start == '0 && r_out.window_end == '0))
        else $error("window bounds set without a hit");

    // A stalled tick stays in the input register
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !out_free) |=> (r_in_valid && $stable(r_in)))
        else $error("stalled tick lost");
`endif

endmodule

[hdl/swvg_slot_match.sv]
// Widens one schedule slot by the lead and lag margins (modulo one day) and
// tests the minute against the half-open window. Depends on swvg_pkg.
module swvg_slot_match
    import swvg_pkg::*;
(
    input  logic [SLOT_W-1:0]   i_slot_word,
    input  logic [MARGIN_W-1:0] i_lead,
    input  logic [MARGIN_W-1:0] i_lag,
    input  logic [MINUTE_W-1:0] i_minute,
    output t_window             o_window
);

    logic [MINUTE_W-1:0] on_m;
    logic [MINUTE_W-1:0] off_m;
    logic                slot_en;
    logic [MINUTE_W:0]   early;
    logic [MINUTE_W:0]   late;
    logic [MINUTE_W-1:0] win_start;
    logic [MINUTE_W-1:0] win_end;
    logic                in_win;

    assign on_m    = i_slot_word[10:0];
    assign off_m   = i_slot_word[21:11];
    assign slot_en = i_slot_word[22];

    // Move start earlier and end later; one fold back into the day suffices
    assign early = {1'b0, on_m} - {{(MINUTE_W+1-MARGIN_W){1'b0}}, i_lead};
    assign late  = {1'b0, off_m} + {{(MINUTE_W+1-MARGIN_W){1'b0}}, i_lag};

    always_comb begin
        if (early[MINUTE_W]) begin
            win_start = early[MINUTE_W-1:0] + MIN_PER_DAY;
        end else if (early >= {1'b0, MIN_PER_DAY}) begin
            win_start = early[MINUTE_W-1:0] - MIN_PER_DAY;
        end else begin
            win_start = early[MINUTE_W-1:0];
        end
    end

    always_comb begin
        if (late >= {1'b0, MIN_PER_DAY}) begin
            win_end = MINUTE_W'(late - {1'b0, MIN_PER_DAY});
        end else begin
            win_end = late[MINUTE_W-1:0];
        end
    end

    // Half-open window, wrapping past midnight when start is above end
    always_comb begin
        if (win_start <= win_end) begin
            in_win = (i_minute >= win_start) && (i_minute < win_end);
        end else begin
            in_win = (i_minute >= win_start) || (i_minute < win_end);
        end
    end

    assign o_window.hit   = slot_en && in_win;
    assign o_window.start = win_start;
    assign o_window.stop  = win_end;

endmodule
